// File: design/row_mean_and_sample_stddev_assert.svh
// assertion macros shared by the row statistics rtl
`ifndef ROW_MEAN_AND_SAMPLE_STDDEV_ASSERT_SVH
`define ROW_MEAN_AND_SAMPLE_STDDEV_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RMSD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define RMSD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/rmsd_pkg.sv
// shared constants, codes and types for the row statistics block
package rmsd_pkg;

   localparam int MAX_COLS = 1024;
   localparam int MAX_ROWS = 1024;

   localparam int SAMPLE_W = 16;
   localparam int ROW_W    = 10;
   localparam int COUNT_W  = 11;
   localparam int SUM_W    = 26;
   localparam int SUMSQ_W  = 42;
   localparam int STATUS_W = 2;

   // datapath of the shared unit, wide enough for n*sumsq and the variance
   localparam int UNIT_W = 54;
   localparam int ROOT_W = UNIT_W / 2;
   localparam int STEP_W = $clog2(UNIT_W);
   localparam int DEN_W  = 2 * COUNT_W;

   localparam logic [1:0] OP_DIV  = 2'd0;
   localparam logic [1:0] OP_MUL  = 2'd1;
   localparam logic [1:0] OP_SQRT = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FEW    = 2'd2;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } rmsd_cmd_type;

endpackage

// File: design/rmsd_unit.sv
// iterative shift/add-subtract unit: restoring divide, shift-add multiply, digit root
module rmsd_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  rmsd_pkg::rmsd_cmd_type     cmd,
   input  logic [rmsd_pkg::UNIT_W-1:0] opa,
   input  logic [rmsd_pkg::UNIT_W-1:0] opb,
   output logic                       busy,
   output logic                       done,
   output logic [rmsd_pkg::UNIT_W-1:0] result,
   output logic [rmsd_pkg::UNIT_W-1:0] remainder
);

   `include "row_mean_and_sample_stddev_assert.svh"

   localparam int W = rmsd_pkg::UNIT_W;

   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;
   logic [1:0]                       op_ff, op_in;
   logic [rmsd_pkg::STEP_W-1:0]      cnt_ff, cnt_in;
   logic [W-1:0]                     rem_ff, rem_in;
   logic [W-1:0]                     acc_ff, acc_in;
   logic [W-1:0]                     src_ff, src_in;
   logic [W-1:0]                     arg_ff, arg_in;

   logic [W:0]                       lhs;
   logic [W:0]                       rhs;
   logic                             sub;
   logic [W+1:0]                     sum_ext;
   logic                             neg;

   // the one adder, shared by every operation
   always_comb begin
      lhs = {1'b0, arg_ff};
      rhs = {1'b0, arg_ff};
      sub = 1'b1;
      unique case (op_ff)
         rmsd_pkg::OP_DIV: begin
            lhs = {rem_ff, src_ff[W-1]};
            rhs = {1'b0, arg_ff};
            sub = 1'b1;
         end
         rmsd_pkg::OP_SQRT: begin
            lhs = {rem_ff[W-2:0], src_ff[W-1:W-2]};
            rhs = {acc_ff[W-2:0], 2'b01};
            sub = 1'b1;
         end
         rmsd_pkg::OP_MUL: begin
            lhs = {acc_ff, 1'b0};
            rhs = src_ff[W-1] ? {1'b0, arg_ff} : '0;
            sub = 1'b0;
         end
         default: begin
            lhs = {1'b0, arg_ff};
            rhs = {1'b0, arg_ff};
            sub = 1'b1;
         end
      endcase
      sum_ext = {1'b0, lhs} + ({1'b0, rhs} ^ {(W+2){sub}}) + {{(W+1){1'b0}}, sub};
      neg     = sum_ext[W+1];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      src_in  = src_ff;
      arg_in  = arg_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         rem_in  = '0;
         acc_in  = '0;
         src_in  = opa;
         arg_in  = opb;
         cnt_in  = (cmd.op == rmsd_pkg::OP_SQRT) ?
                   rmsd_pkg::STEP_W'(rmsd_pkg::ROOT_W - 1) :
                   rmsd_pkg::STEP_W'(W - 1);
      end else if (busy_ff) begin
         unique case (op_ff)
            rmsd_pkg::OP_DIV: begin
               rem_in = neg ? lhs[W-1:0] : sum_ext[W-1:0];
               acc_in = {acc_ff[W-2:0], ~neg};
               src_in = {src_ff[W-2:0], 1'b0};
            end
            rmsd_pkg::OP_SQRT: begin
               rem_in = neg ? lhs[W-1:0] : sum_ext[W-1:0];
               acc_in = {acc_ff[W-2:0], ~neg};
               src_in = {src_ff[W-3:0], 2'b00};
            end
            rmsd_pkg::OP_MUL: begin
               acc_in = sum_ext[W-1:0];
               src_in = {src_ff[W-2:0], 1'b0};
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= rmsd_pkg::OP_DIV;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      src_ff <= src_in;
      arg_ff <= arg_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign result    = acc_ff;
   assign remainder = rem_ff;

   `RMSD_ASSERT_NOW(a_start_when_idle, cmd.start, !busy_ff, "unit started while busy")
   `RMSD_ASSERT_NEXT(a_done_after_busy, busy_ff && cnt_ff == '0 && !cmd.start, done_ff && !busy_ff,
      "unit did not finish on its last step")
   `RMSD_ASSERT_NOW(a_root_steps, busy_ff && op_ff == rmsd_pkg::OP_SQRT,
      cnt_ff < rmsd_pkg::STEP_W'(rmsd_pkg::ROOT_W), "root ran past its step count")

endmodule

// File: design/row_mean_and_sample_stddev.sv
// Row mean and sample standard deviation over a matrix streamed in row-major order.
// While a matrix streams in, one element is taken every cycle and elements of the row in
// csr_selected_row go into a count, a sum and a sum of squares. The element flagged
// end_of_matrix closes the matrix: req_stall then stays high while one shared
// shift/add-subtract unit, one bit or one root digit per cycle, works out the rounded
// mean (54-step divide), n*sumsq, sum^2 and n*(n-1) (54-step multiplies), the rounded
// variance (54-step divide) and its rounded root (27 steps); an absent row skips the
// unit and a single element stops after the mean. The result sits in an output register,
// so elements of the next matrix are taken while it waits; only a further end_of_matrix
// is held back until the result is taken. status 1 means the row had no elements, 2 means
// only one (mean given, deviation 0). csr writes are always taken.
module row_mean_and_sample_stddev (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [rmsd_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [rmsd_pkg::ROW_W-1:0]          req_row_number,
   input  logic                                req_end_of_matrix,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rmsd_pkg::SAMPLE_W-1:0] rsp_row_mean,
   output logic [rmsd_pkg::SAMPLE_W-1:0]       rsp_row_stddev,
   output logic [rmsd_pkg::STATUS_W-1:0]       rsp_status,
   output logic [rmsd_pkg::COUNT_W-1:0]        rsp_element_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rmsd_pkg::ROW_W-1:0]          csr_selected_row
);

   `include "row_mean_and_sample_stddev_assert.svh"

   localparam int W = rmsd_pkg::UNIT_W;

   localparam logic [3:0] S_ACC    = 4'd0;
   localparam logic [3:0] S_CHK    = 4'd1;
   localparam logic [3:0] S_MEAN   = 4'd2;
   localparam logic [3:0] S_SQS    = 4'd3;
   localparam logic [3:0] S_MAG2   = 4'd4;
   localparam logic [3:0] S_DEN    = 4'd5;
   localparam logic [3:0] S_DIFF   = 4'd6;
   localparam logic [3:0] S_VSTART = 4'd7;
   localparam logic [3:0] S_VAR    = 4'd8;
   localparam logic [3:0] S_ROOT   = 4'd9;

   logic [3:0]                           state_ff, state_in;
   logic [rmsd_pkg::ROW_W-1:0]           sel_ff, sel_in;
   logic signed [rmsd_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [rmsd_pkg::SUMSQ_W-1:0]         sumsq_ff, sumsq_in;
   logic [rmsd_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [W-1:0]                         a_ff, a_in;
   logic [W-1:0]                         b_ff, b_in;
   logic [rmsd_pkg::DEN_W-1:0]           den_ff, den_in;
   logic signed [rmsd_pkg::SAMPLE_W-1:0] mean_ff, mean_in;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic signed [rmsd_pkg::SAMPLE_W-1:0] rsp_mean_ff, rsp_mean_in;
   logic [rmsd_pkg::SAMPLE_W-1:0]        rsp_sd_ff, rsp_sd_in;
   logic [rmsd_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [rmsd_pkg::COUNT_W-1:0]         rsp_count_ff, rsp_count_in;

   logic                                 accept;
   logic                                 hit;
   logic signed [2*rmsd_pkg::SAMPLE_W-1:0] square;
   logic [rmsd_pkg::SUM_W-1:0]           mag;
   logic                                 finish;
   logic [rmsd_pkg::SAMPLE_W-1:0]        quot16;
   logic [rmsd_pkg::ROOT_W:0]            root_rnd;

   rmsd_pkg::rmsd_cmd_type               cmd;
   logic [W-1:0]                         opa;
   logic [W-1:0]                         opb;
   logic                                 unit_busy;
   logic                                 unit_done;
   logic [W-1:0]                         unit_result;
   logic [W-1:0]                         unit_rem;

   rmsd_unit u_unit (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .opa       (opa),
      .opb       (opb),
      .busy      (unit_busy),
      .done      (unit_done),
      .result    (unit_result),
      .remainder (unit_rem)
   );

   // a closing item waits while the previous result is still held
   assign req_stall = (state_ff != S_ACC) || (rsp_valid_ff && req_end_of_matrix);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign hit    = accept && (req_row_number == sel_ff) &&
                   (int'(req_row_number) < rmsd_pkg::MAX_ROWS) &&
                   (int'(count_ff) < rmsd_pkg::MAX_COLS);
   assign square = req_sample * req_sample;
   assign mag    = sum_ff[rmsd_pkg::SUM_W-1] ? rmsd_pkg::SUM_W'(-sum_ff) :
                   rmsd_pkg::SUM_W'(sum_ff);
   assign quot16 = unit_result[rmsd_pkg::SAMPLE_W-1:0];
   assign root_rnd = {1'b0, unit_result[rmsd_pkg::ROOT_W-1:0]} +
                     (rmsd_pkg::ROOT_W+1)'(unit_rem > unit_result);

   always_comb begin
      state_in      = state_ff;
      sel_in        = csr_valid ? csr_selected_row : sel_ff;
      sum_in        = sum_ff;
      sumsq_in      = sumsq_ff;
      count_in      = count_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      den_in        = den_ff;
      mean_in       = mean_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_mean_in   = rsp_mean_ff;
      rsp_sd_in     = rsp_sd_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      finish        = 1'b0;
      cmd.start     = 1'b0;
      cmd.op        = rmsd_pkg::OP_DIV;
      opa           = '0;
      opb           = '0;

      if (hit) begin
         sum_in   = sum_ff + rmsd_pkg::SUM_W'(req_sample);
         sumsq_in = sumsq_ff + rmsd_pkg::SUMSQ_W'($unsigned(square));
         count_in = count_ff + 1'b1;
      end

      unique case (state_ff)
         S_ACC: begin
            if (accept && req_end_of_matrix) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (count_ff == '0) begin
               finish        = 1'b1;
               rsp_mean_in   = '0;
               rsp_sd_in     = '0;
               rsp_status_in = rmsd_pkg::STATUS_ABSENT;
            end else begin
               cmd.start = 1'b1;
               cmd.op    = rmsd_pkg::OP_DIV;
               opa       = W'(mag) + W'(count_ff >> 1);
               opb       = W'(count_ff);
               state_in  = S_MEAN;
            end
         end
         S_MEAN: begin
            if (unit_done) begin
               mean_in = sum_ff[rmsd_pkg::SUM_W-1] ? rmsd_pkg::SAMPLE_W'(-quot16) :
                         rmsd_pkg::SAMPLE_W'(quot16);
               if (count_ff < rmsd_pkg::COUNT_W'(2)) begin
                  finish        = 1'b1;
                  rsp_mean_in   = mean_in;
                  rsp_sd_in     = '0;
                  rsp_status_in = rmsd_pkg::STATUS_FEW;
               end else begin
                  cmd.start = 1'b1;
                  cmd.op    = rmsd_pkg::OP_MUL;
                  opa       = W'(count_ff);
                  opb       = W'(sumsq_ff);
                  state_in  = S_SQS;
               end
            end
         end
         S_SQS: begin
            if (unit_done) begin
               a_in      = unit_result;
               cmd.start = 1'b1;
               cmd.op    = rmsd_pkg::OP_MUL;
               opa       = W'(mag);
               opb       = W'(mag);
               state_in  = S_MAG2;
            end
         end
         S_MAG2: begin
            if (unit_done) begin
               b_in      = unit_result;
               cmd.start = 1'b1;
               cmd.op    = rmsd_pkg::OP_MUL;
               opa       = W'(count_ff);
               opb       = W'(count_ff - 1'b1);
               state_in  = S_DEN;
            end
         end
         S_DEN: begin
            if (unit_done) begin
               den_in   = unit_result[rmsd_pkg::DEN_W-1:0];
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            // variance numerator, clamped at zero
            a_in     = (a_ff > b_ff) ? (a_ff - b_ff) : '0;
            state_in = S_VSTART;
         end
         S_VSTART: begin
            cmd.start = 1'b1;
            cmd.op    = rmsd_pkg::OP_DIV;
            opa       = a_ff + W'(den_ff >> 1);
            opb       = W'(den_ff);
            state_in  = S_VAR;
         end
         S_VAR: begin
            if (unit_done) begin
               cmd.start = 1'b1;
               cmd.op    = rmsd_pkg::OP_SQRT;
               opa       = unit_result;
               state_in  = S_ROOT;
            end
         end
         S_ROOT: begin
            if (unit_done) begin
               finish        = 1'b1;
               rsp_mean_in   = mean_ff;
               rsp_sd_in     = (root_rnd > (rmsd_pkg::ROOT_W+1)'(16'hFFFF)) ? 16'hFFFF :
                               root_rnd[rmsd_pkg::SAMPLE_W-1:0];
               rsp_status_in = rmsd_pkg::STATUS_OK;
            end
         end
         default: begin
            state_in = S_ACC;
         end
      endcase

      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = count_ff;
         sum_in       = '0;
         sumsq_in     = '0;
         count_in     = '0;
         state_in     = S_ACC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACC;
         sel_ff       <= '0;
         sum_ff       <= '0;
         sumsq_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         sum_ff       <= sum_in;
         sumsq_ff     <= sumsq_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff          <= a_in;
      b_ff          <= b_in;
      den_ff        <= den_in;
      mean_ff       <= mean_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_sd_ff     <= rsp_sd_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_row_mean      = rsp_mean_ff;
   assign rsp_row_stddev    = rsp_sd_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;

   `RMSD_ASSERT_NOW(a_count_bound, 1'b1,
      int'(count_ff) <= rmsd_pkg::MAX_COLS, "element count above row limit")
   `RMSD_ASSERT_NOW(a_result_clears, $rose(rsp_valid_ff),
      count_ff == '0 && sum_ff == '0 && sumsq_ff == '0, "accumulators not cleared at result")
   `RMSD_ASSERT_NOW(a_ok_needs_two, $rose(rsp_valid_ff) && rsp_status_ff == rmsd_pkg::STATUS_OK,
      rsp_count_ff >= rmsd_pkg::COUNT_W'(2), "ok status with fewer than two elements")
   `RMSD_ASSERT_NOW(a_unit_in_compute, unit_busy,
      state_ff == S_MEAN || state_ff == S_SQS || state_ff == S_MAG2 ||
      state_ff == S_DEN || state_ff == S_VAR || state_ff == S_ROOT,
      "shared unit busy outside a compute step")

endmodule
